// ===== rtl/core/bcc_pkg.sv =====
package bcc_pkg;

  // Width of the saturating hold and idle timers.
  localparam int unsigned TimerBits = 16;

  // Configuration registers are 16 bits wide; timers are compared in the wider of the two.
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned CmpBits     = (TimerBits > CfgDataBits) ? TimerBits : CfgDataBits;
  localparam int unsigned CfgIdxBits  = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgLongPress = 2'd0,
    CfgClickGap  = 2'd1,
    CfgExpire    = 2'd2
  } cfg_reg_e;

  localparam logic [CfgDataBits-1:0] LongPressReset = 16'd3000;
  localparam logic [CfgDataBits-1:0] ClickGapReset  = 16'd500;
  localparam logic [CfgDataBits-1:0] ExpireReset    = 16'd1000;

  // Press counter codes.
  localparam int unsigned CountBits = 4;
  localparam logic [CountBits-1:0] CountZero = 4'd0;
  localparam logic [CountBits-1:0] CountMax4 = 4'd4;
  localparam logic [CountBits-1:0] CountSat  = 4'd14;
  localparam logic [CountBits-1:0] LongMark  = 4'd15;

  // Flag vector layout.
  localparam int unsigned FlagBits  = 6;
  localparam int unsigned FlagLong  = 4;
  localparam int unsigned FlagError = 5;

  typedef struct packed {
    logic [FlagBits-1:0] clear_mask;
    logic                button_level;
  } in_item_t;

  typedef struct packed {
    logic click_error;
    logic long_hold;
    logic quad_click;
    logic triple_click;
    logic double_click;
    logic single_click;
  } out_item_t;

endpackage

// ===== rtl/core/bcc_if.sv =====
interface bcc_in_if;
  import bcc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bcc_out_if;
  import bcc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/button_click_classifier_core.sv =====
// Multi-click and long-press classifier for one button. Each input item is one
// millisecond tick with the sampled button level and a mask of flags to clear
// after they have been reported; each item yields exactly one result item with
// the six flags (single, double, triple, quad click, long hold, click error).
// Releases closer together than click_gap_ms form one sequence, which is
// classified once the button has stayed idle longer than that gap; a hold
// longer than long_press_ms raises the long-hold flag (again every further
// period) and its release counts no click; unread flags clear after more than
// expire_ms idle ticks. The block takes one item per clock cycle unless the
// result register stalls; each item passes through the input register, then
// through the state update into the result register. That state update is a
// single pass of timer increment, compare and flag logic, so nothing limits
// the rate below one item per cycle. Both stages stall only when the result
// register is full and not being taken. Configuration registers are written
// through the plain write port; the user must do so only while no item is in
// flight, which the block does not enforce. Unknown indices are ignored.
module button_click_classifier_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [bcc_pkg::CfgDataBits-1:0] cfg_data_i,
  bcc_in_if.sink                         in_i,
  bcc_out_if.source                      out_o
);
  import bcc_pkg::*;

  // Configuration registers.
  logic [CfgDataBits-1:0] long_press_q, click_gap_q, expire_q;

  // Pipeline control and payload.
  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q, out_item_d;
  logic      advance;

  // Classifier state.
  logic                 button_down_q, button_down_d;
  logic [TimerBits-1:0] held_q, held_d;
  logic [TimerBits-1:0] idle_q, idle_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [FlagBits-1:0]  flags_q, flags_d, flags_out;

  logic [TimerBits-1:0] held_inc, idle_inc;

  // The result register moves on when it is empty or being taken; the input
  // register moves into it at the same time.
  assign advance     = !out_vld_q || out_o.ready;
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_item_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressReset;
      click_gap_q  <= ClickGapReset;
      expire_q     <= ExpireReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLongPress: long_press_q <= cfg_data_i;
        CfgClickGap:  click_gap_q  <= cfg_data_i;
        CfgExpire:    expire_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturating timer increments.
  assign held_inc = (held_q == {TimerBits{1'b1}}) ? held_q : held_q + TimerBits'(1);
  assign idle_inc = (idle_q == {TimerBits{1'b1}}) ? idle_q : idle_q + TimerBits'(1);

  // One tick of the classifier, applied to the item in the input register.
  always_comb begin
    button_down_d = button_down_q;
    held_d        = held_q;
    idle_d        = idle_q;
    count_d       = count_q;
    flags_out     = flags_q;

    if (!button_down_q && in_item_q.button_level) begin
      // A press begins.
      button_down_d = 1'b1;
      held_d        = '0;
    end else if (button_down_q && in_item_q.button_level) begin
      // Still held: past the threshold the long-hold flag rises, the hold
      // timer restarts and the counter takes the long-hold marker.
      held_d = held_inc;
      if (CmpBits'(held_inc) > CmpBits'(long_press_q)) begin
        flags_out[FlagLong] = 1'b1;
        held_d              = '0;
        count_d             = LongMark;
      end
    end else if (button_down_q && !in_item_q.button_level) begin
      // Release: a long hold counts no click, otherwise count up to saturation.
      button_down_d = 1'b0;
      idle_d        = '0;
      if (count_q == LongMark) begin
        count_d = CountZero;
      end else if (count_q < CountSat) begin
        count_d = count_q + CountBits'(1);
      end
    end else begin
      // Idle: end the sequence after the gap, drop all flags after expiry.
      idle_d = idle_inc;
      if (CmpBits'(idle_inc) > CmpBits'(click_gap_q)) begin
        if (count_q != CountZero && count_q <= CountMax4) begin
          flags_out[{1'b0, count_q[1:0] - 2'd1}] = 1'b1;
        end else if (count_q > CountMax4 && count_q <= CountSat) begin
          flags_out[FlagError] = 1'b1;
        end
        count_d = CountZero;
      end
      if (CmpBits'(idle_inc) > CmpBits'(expire_q)) begin
        flags_out = '0;
      end
    end

    flags_d    = flags_out & ~in_item_q.clear_mask;
    out_item_d = out_item_t'(flags_out);
  end

  // Pipeline valid bits and classifier state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      button_down_q <= 1'b0;
      held_q        <= '0;
      idle_q        <= '0;
      count_q       <= CountZero;
      flags_q       <= '0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (advance && in_vld_q) begin
        button_down_q <= button_down_d;
        held_q        <= held_d;
        idle_q        <= idle_d;
        count_q       <= count_d;
        flags_q       <= flags_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
    if (advance && in_vld_q) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

// ===== rtl/core/bcc_checker.sv =====
module bcc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bcc_pkg::out_item_t  out_payload_i
);
  import bcc_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item withdrawn while stalled");

  // A stalled result keeps its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("result item changed while stalled");

  // The input side only stalls behind a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without back-pressure");

  // A fresh result follows an accepted item through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result item without an accepted input item");

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the button click classifier. Every accepted input item
// is run through a predictor of the classifier, and the flags it produces are
// queued. Every result item is then checked field by field against the oldest
// queued flags. The stimulus is made of button gestures under a series of timing
// settings: clicks, long holds, broken sequences and noise.
module tb;
  import bcc_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int ResetCycles = 10;
  localparam int MaxWait     = 8;
  // Quiet cycles allowed before the run is declared hung. The longest legal
  // silence is the receiver hold-off plus a drain, well below this.
  localparam int QuietLimit  = 2000;
  // The core holds at most two items in flight, so a few cycles settle it.
  localparam int DrainCycles = 6;
  localparam int RandomTicks = 1950;
  localparam int PhaseTicks  = 250;
  localparam int HoldOffCycles = 60;
  // The index port is two bits wide, and the last code selects no register.
  localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;
  localparam logic [FlagBits-1:0] MaskNone = '0;
  localparam logic [FlagBits-1:0] MaskAll  = '1;

  // Predicts the flag vector for every tick and keeps the flags still owed by
  // the core.
  class flag_scoreboard;
    logic [CfgDataBits-1:0] long_limit, gap_limit, expire_limit;
    logic                   btn_down;
    logic [TimerBits-1:0]   held, idle;
    logic [CountBits-1:0]   presses;
    logic [FlagBits-1:0]    flags;
    out_item_t              owed_flags[$];
    int                     errors;
    int                     flag_hits[FlagBits];

    function new();
      long_limit   = LongPressReset;
      gap_limit    = ClickGapReset;
      expire_limit = ExpireReset;
      btn_down = 1'b0;
      held     = '0;
      idle     = '0;
      presses  = CountZero;
      flags    = '0;
      errors   = 0;
      foreach (flag_hits[j]) flag_hits[j] = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] value);
      case (idx)
        CfgLongPress: long_limit   = value;
        CfgClickGap:  gap_limit    = value;
        CfgExpire:    expire_limit = value;
        default: ;
      endcase
    endfunction

    // Advances the predicted state by one tick and queues the reported flags.
    function void note_tick(in_item_t tick);
      if (!btn_down && tick.button_level) begin
        btn_down = 1'b1;
        held     = '0;
      end else if (btn_down && tick.button_level) begin
        held = (held == '1) ? held : held + 1'b1;
        if (held > long_limit) begin
          flags[FlagLong] = 1'b1;
          held    = '0;
          presses = LongMark;
        end
      end else if (btn_down) begin
        btn_down = 1'b0;
        idle     = '0;
        if (presses == LongMark) presses = CountZero;
        else if (presses < CountSat) presses = presses + 1'b1;
      end else begin
        idle = (idle == '1) ? idle : idle + 1'b1;
        if (idle > gap_limit) begin
          if (presses != CountZero && presses <= CountMax4) flags[presses - 1'b1] = 1'b1;
          else if (presses > CountMax4 && presses <= CountSat) flags[FlagError] = 1'b1;
          presses = CountZero;
        end
        if (idle > expire_limit) flags = '0;
      end
      owed_flags.push_back(out_item_t'(flags));
      flags = flags & ~tick.clear_mask;
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %b, got %b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_flags(out_item_t got);
      out_item_t        want;
      logic [FlagBits-1:0] bits;
      if (owed_flags.size() == 0) begin
        $display("%0t ns: result %b arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = owed_flags.pop_front();
      compare_field("single_click", want.single_click, got.single_click);
      compare_field("double_click", want.double_click, got.double_click);
      compare_field("triple_click", want.triple_click, got.triple_click);
      compare_field("quad_click", want.quad_click, got.quad_click);
      compare_field("long_hold", want.long_hold, got.long_hold);
      compare_field("click_error", want.click_error, got.click_error);
      bits = got;
      for (int j = 0; j < FlagBits; j++) if (bits[j] === 1'b1) flag_hits[j]++;
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;

  bcc_in_if  in_if ();
  bcc_out_if out_if ();

  button_click_classifier_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  flag_scoreboard sb;

  // Random idling on both sides is switched off for some stretches.
  bit idle_on;
  // Counts the requests from the stimulus for the receiver to stop taking
  // results for a while.
  int hold_asked;
  int ticks_sent;
  int settings_used;
  int quiet = 0;
  // Gesture lengths for the current setting, capped so that huge register
  // values do not make single gestures run for thousands of ticks.
  int press_span, gap_span, expire_span;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Scoreboard hookup. Both channels are sampled at the rising edge, so the
  // values seen are the ones the core acted on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_tick(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check_flags(out_if.payload);
    end
  end

  // Watchdog: a long run of cycles with no item moving on either side means the
  // core has hung or lost an item.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t ns: no item moved for %0d cycles", $time, QuietLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result receiver. For every result it stalls a random number of cycles and
  // then holds ready until a result is taken. On request it holds off for a
  // long stretch so that the core fills up and stalls its input.
  initial begin : receiver
    int  stall;
    bit  taken;
    int  hold_done;
    hold_done = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_asked > hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_done++;
      end else begin
        stall = idle_on ? $urandom_range(0, MaxWait) : 0;
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        out_if.ready <= 1'b1;
        do begin
          @(posedge clk_i);
          taken = out_if.valid;
          @(negedge clk_i);
        end while (!taken);
      end
    end
  end

  // Offers one tick after a random gap and returns at the falling edge after it
  // has been accepted. Valid stays high so back-to-back items need no gap.
  task automatic send_tick(input bit level, input logic [FlagBits-1:0] mask);
    int       gap;
    bit       taken;
    in_item_t tick;
    gap = idle_on ? $urandom_range(0, MaxWait) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick.button_level = level;
    tick.clear_mask   = mask;
    in_if.payload <= tick;
    in_if.valid   <= 1'b1;
    do begin
      @(posedge clk_i);
      taken = in_if.ready;
      @(negedge clk_i);
    end while (!taken);
    ticks_sent++;
  endtask

  // Mostly no clear, so that flags stay visible over several ticks; sometimes a
  // partial read and sometimes a full read.
  function automatic logic [FlagBits-1:0] pick_mask();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return MaskNone;
    if (pick < 9) return FlagBits'($urandom_range(0, 63));
    return MaskAll;
  endfunction

  task automatic hold_level(input bit level, input int n);
    repeat (n) send_tick(level, pick_mask());
  endtask

  // Stops offering items and waits until every owed result has come back, then
  // lets the core settle.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (sb.owed_flags.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Drives one register write and then lowers the write enable.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  // Writes a full timing setting while the core is idle.
  task automatic configure(input logic [CfgDataBits-1:0] long_ms,
                           input logic [CfgDataBits-1:0] gap_ms,
                           input logic [CfgDataBits-1:0] expire_ms);
    wait_for_results();
    write_reg(CfgLongPress, long_ms);
    write_reg(CfgClickGap, gap_ms);
    write_reg(CfgExpire, expire_ms);
    press_span  = (long_ms > 12) ? 12 : long_ms;
    gap_span    = (gap_ms > 8) ? 8 : gap_ms;
    expire_span = (expire_ms > 24) ? 24 : expire_ms;
    settings_used++;
  endtask

  // Short directed taps: one tick pressed, one tick released, and a final idle
  // tick that reads the flags. Used with a click gap of zero.
  task automatic tap_run(input int taps);
    repeat (taps) begin
      send_tick(1'b1, MaskNone);
      send_tick(1'b0, MaskNone);
    end
    send_tick(1'b0, MaskAll);
  endtask

  // A run of short clicks whose releases stay within the click gap.
  task automatic click_run(input int clicks);
    repeat (clicks) begin
      hold_level(1'b1, $urandom_range(1, press_span + 1));
      hold_level(1'b0, $urandom_range(1, gap_span + 1));
    end
  endtask

  initial begin : stimulus
    int phase_ticks;
    int pick;
    int clicks;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgLongPress;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    idle_on       = 1'b0;
    hold_asked    = 0;
    ticks_sent    = 0;
    settings_used = 1;
    press_span    = 12;
    gap_span      = 8;
    expire_span   = 24;
    sb = new();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. A tap under the reset timing sets nothing yet.
    send_tick(1'b1, MaskNone);
    send_tick(1'b0, MaskNone);
    send_tick(1'b0, MaskAll);
    // Zero registers make every comparison true after one tick. The unused
    // index must leave all three registers alone.
    configure('0, '0, 16'd1);
    write_reg(CfgUnused, '1);
    tap_run(1);
    tap_run(4);
    // Five taps overflow the click classes and set the error flag.
    tap_run(5);
    // A two-tick hold beats a zero long-press time; its release counts no click.
    send_tick(1'b1, MaskNone);
    send_tick(1'b1, MaskNone);
    send_tick(1'b0, MaskAll);

    // Random part, in phases of one timing setting each.
    configure(16'd6, 16'd3, 16'd10);
    idle_on = 1'b1;
    // Back pressure: the receiver holds off while noise ticks keep coming, so
    // the core fills and stalls its input. Then the sender drains everything.
    hold_asked++;
    repeat (20) send_tick(1'($urandom_range(0, 1)), pick_mask());
    wait_for_results();

    phase_ticks = 0;
    while (ticks_sent < RandomTicks) begin
      if (phase_ticks >= PhaseTicks) begin
        pick = $urandom_range(0, 5);
        if (settings_used == 3) configure('1, '1, '1);
        else if (settings_used == 4) configure(16'd1, 16'd1, 16'd1);
        else if (pick == 0) begin
          // Expiry no longer than the gap clears a fresh flag in its own tick.
          configure(16'($urandom_range(1, 12)), 16'(8), 16'($urandom_range(1, 8)));
        end else begin
          configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                    16'($urandom_range(1, 24)));
        end
        phase_ticks = 0;
      end
      idle_on = ($urandom_range(0, 3) != 0);
      phase_ticks -= ticks_sent;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        // A well-formed click sequence; now and then one long enough to saturate
        // the press counter.
        clicks = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 17) : $urandom_range(1, 4);
        click_run(clicks);
        hold_level(1'b0, gap_span + 1 + $urandom_range(0, expire_span + 2));
      end else if (pick < 7) begin
        // A long hold, sometimes after a few clicks that it throws away.
        click_run($urandom_range(0, 2));
        hold_level(1'b1, press_span + 2 + $urandom_range(0, 2 * press_span + 3));
        hold_level(1'b0, $urandom_range(1, gap_span + expire_span + 3));
      end else if (pick == 7) begin
        hold_level(1'b0, $urandom_range(1, 4));
        send_tick(1'b0, MaskAll);
      end else begin
        repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)), pick_mask());
      end
      phase_ticks += ticks_sent;
    end

    wait_for_results();
    $display("Sent %0d ticks over %0d timing settings, with clicks, long holds and noise.",
             ticks_sent, settings_used);
    $display("Flags seen set: single %0d, double %0d, triple %0d, quad %0d, long %0d, error %0d",
             sb.flag_hits[0], sb.flag_hits[1], sb.flag_hits[2], sb.flag_hits[3],
             sb.flag_hits[FlagLong], sb.flag_hits[FlagError]);
    if (sb.errors == 0 && sb.owed_flags.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
